// ===== design/sst_pkg.sv =====
// Package for the sorted score table: widths, modes, status codes and the
// command word that runs from the front end to the back end. No dependencies.
package sst_pkg;
   localparam int Depth      = 16;
   localparam int IdBits     = 16;
   localparam int ScoreBits  = 16;
   localparam int IdxBits    = $clog2(Depth);
   localparam int CntBits    = $clog2(Depth + 1);

   localparam logic [2:0] MODE_INSERT = 3'd0;
   localparam logic [2:0] MODE_DELETE = 3'd1;
   localparam logic [2:0] MODE_LIST   = 3'd2;
   localparam logic [2:0] MODE_LOWEST = 3'd3;
   localparam logic [2:0] MODE_SAME   = 3'd4;
   localparam logic [2:0] MODE_BEHIND = 3'd5;

   localparam logic [2:0] ST_ENTRY    = 3'd0;
   localparam logic [2:0] ST_DONE     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_NOMATCH  = 3'd5;

   typedef struct packed {
      logic [2:0]           mode;
      logic [IdBits-1:0]    player_id;
      logic [ScoreBits-1:0] score;
   } cmd_type;
endpackage

// ===== design/sst_front.sv =====
// Front end of the sorted score table: accepts request words, drops modes with
// no meaning and queues the rest for the back end. Uses sst_pkg.
module sst_front import sst_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [2:0]           req_mode,
   input  logic [IdBits-1:0]    req_player_id,
   input  logic [ScoreBits-1:0] req_score,
   output logic                 cmd_valid,
   output cmd_type              cmd,
   input  logic                 cmd_take
);
   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   logic       push_ok, keep;

   assign req_full  = (cnt_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign keep      = push_ok && (req_mode <= MODE_BEHIND);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, keep} - {1'b0, cmd_take && cmd_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (keep) begin
            q_ff[wr_ff] <= '{mode: req_mode, player_id: req_player_id, score: req_score};
            wr_ff       <= ~wr_ff;
         end
         if (cmd_take && cmd_valid) rd_ff <= ~rd_ff;
      end
   end
endmodule

// ===== design/sst_back.sv =====
// Back end of the sorted score table: holds the ordered entries, runs one
// command at a time and writes result words into a two-entry output queue.
// Uses sst_pkg.
module sst_back import sst_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  cmd_type               cmd,
   output logic                  cmd_take,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [2:0]            rsp_status,
   output logic [IdBits-1:0]     rsp_out_id,
   output logic [ScoreBits-1:0]  rsp_out_score,
   output logic                  rsp_last
);
   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EMIT, S_SHIFT} state_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [IdBits-1:0]    id;
      logic [ScoreBits-1:0] score;
      logic                 last;
   } rsp_type;

   logic [IdBits-1:0]    id_ff    [Depth];
   logic [ScoreBits-1:0] score_ff [Depth];
   logic [CntBits-1:0]   count_ff;
   state_type            state_ff;
   cmd_type              cur_ff;
   logic [CntBits-1:0]   idx_ff;
   logic [ScoreBits-1:0] min_ff;

   rsp_type    oq_ff [2];
   logic [1:0] ocnt_ff;
   logic       ord_ff, owr_ff;
   rsp_type    ow;
   logic       owe, opop;
   logic       room;
   logic       at_end;
   logic       hit_id, hit_score;

   logic [IdxBits-1:0] ix, ixm1, ixp1;
   assign ix   = idx_ff[IdxBits-1:0];
   assign ixm1 = ix - 1'b1;
   assign ixp1 = ix + 1'b1;

   assign opop          = rsp_pop && !rsp_empty;
   assign rsp_empty     = (ocnt_ff == 2'd0);
   assign rsp_status    = oq_ff[ord_ff].status;
   assign rsp_out_id    = oq_ff[ord_ff].id;
   assign rsp_out_score = oq_ff[ord_ff].score;
   assign rsp_last      = oq_ff[ord_ff].last;

   assign room      = (ocnt_ff != 2'd2);
   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid && room;
   assign at_end    = ({1'b0, idx_ff} + 1'b1) >= {1'b0, count_ff};
   assign hit_id    = (id_ff[ix] == cur_ff.player_id);
   assign hit_score = (score_ff[ix] == cur_ff.score);

   always_comb begin
      owe = 1'b0;
      ow  = '{status: ST_DONE, id: '0, score: '0, last: 1'b1};
      if (room) begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  priority if (cmd.mode == MODE_INSERT) begin
                     if (count_ff == CntBits'(Depth)) begin
                        owe = 1'b1; ow.status = ST_FULL;
                     end
                  end else if (cmd.mode == MODE_DELETE ||
                               cmd.mode == MODE_LIST || cmd.mode == MODE_LOWEST) begin
                     if (count_ff == '0) begin
                        owe = 1'b1; ow.status = ST_EMPTY;
                     end
                  end else if (count_ff == '0) begin
                     owe = 1'b1;
                     ow.status = (cmd.mode == MODE_SAME) ? ST_NOMATCH : ST_NOTFOUND;
                  end
               end
            end
            S_SCAN: begin
               unique case (cur_ff.mode)
                  MODE_LIST: begin
                     owe = 1'b1;
                     ow  = '{status: ST_ENTRY, id: id_ff[ix], score: score_ff[ix], last: at_end};
                  end
                  MODE_LOWEST: begin
                     owe = 1'b1;
                     ow  = '{status: ST_ENTRY, id: id_ff[ix], score: score_ff[ix],
                             last: at_end || (score_ff[ixp1] != min_ff)};
                  end
                  MODE_SAME: begin
                     if (hit_score) begin
                        owe = 1'b1;
                        ow  = '{status: ST_ENTRY, id: id_ff[ix], score: score_ff[ix],
                                last: at_end || (score_ff[ixp1] != cur_ff.score)};
                     end else if (at_end || score_ff[ix] > cur_ff.score) begin
                        owe = 1'b1; ow.status = ST_NOMATCH;
                     end
                  end
                  MODE_DELETE, MODE_BEHIND: begin
                     if (at_end && !hit_id) begin
                        owe = 1'b1; ow.status = ST_NOTFOUND;
                     end else if (hit_id && cur_ff.mode == MODE_BEHIND && idx_ff == '0) begin
                        owe = 1'b1; ow.status = ST_DONE;
                     end
                  end
                  default: ;
               endcase
            end
            S_EMIT: begin
               owe = 1'b1;
               ow  = '{status: ST_ENTRY, id: id_ff[ixm1], score: score_ff[ixm1],
                       last: (idx_ff == CntBits'(1))};
            end
            S_SHIFT: begin
               if ((cur_ff.mode == MODE_INSERT && (idx_ff == '0 ||
                    score_ff[ixm1] <= cur_ff.score)) ||
                   (cur_ff.mode == MODE_DELETE && at_end)) begin
                  owe = 1'b1; ow.status = ST_DONE;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ocnt_ff  <= 2'd0;
         ord_ff   <= 1'b0;
         owr_ff   <= 1'b0;
      end else begin
         ocnt_ff <= ocnt_ff + {1'b0, owe} - {1'b0, opop};
         if (owe) begin
            oq_ff[owr_ff] <= ow;
            owr_ff        <= ~owr_ff;
         end
         if (opop) ord_ff <= ~ord_ff;
         if (room) begin
            unique case (state_ff)
               S_IDLE: begin
                  if (cmd_valid) begin
                     cur_ff <= cmd;
                     min_ff <= score_ff[0];
                     if (!owe) begin
                        if (cmd.mode == MODE_INSERT) begin
                           state_ff <= S_SHIFT;
                           idx_ff   <= count_ff;
                        end else begin
                           state_ff <= S_SCAN;
                           idx_ff   <= '0;
                        end
                     end
                  end
               end
               S_SCAN: begin
                  unique case (cur_ff.mode)
                     MODE_LIST: begin
                        idx_ff <= idx_ff + 1'b1;
                        if (at_end) state_ff <= S_IDLE;
                     end
                     MODE_LOWEST, MODE_SAME: begin
                        idx_ff <= idx_ff + 1'b1;
                        if (owe && ow.last) state_ff <= S_IDLE;
                     end
                     MODE_DELETE: begin
                        if (hit_id) state_ff <= S_SHIFT;
                        else begin
                           idx_ff <= idx_ff + 1'b1;
                           if (at_end) state_ff <= S_IDLE;
                        end
                     end
                     MODE_BEHIND: begin
                        if (hit_id) state_ff <= (idx_ff == '0) ? S_IDLE : S_EMIT;
                        else begin
                           idx_ff <= idx_ff + 1'b1;
                           if (at_end) state_ff <= S_IDLE;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
               S_EMIT: begin
                  idx_ff <= idx_ff - 1'b1;
                  if (idx_ff == CntBits'(1)) state_ff <= S_IDLE;
               end
               S_SHIFT: begin
                  if (cur_ff.mode == MODE_INSERT) begin
                     if (idx_ff == '0 || score_ff[ixm1] <= cur_ff.score) begin
                        id_ff[ix]    <= cur_ff.player_id;
                        score_ff[ix] <= cur_ff.score;
                        count_ff     <= count_ff + 1'b1;
                        state_ff     <= S_IDLE;
                     end else begin
                        id_ff[ix]    <= id_ff[ixm1];
                        score_ff[ix] <= score_ff[ixm1];
                        idx_ff       <= idx_ff - 1'b1;
                     end
                  end else begin
                     if (at_end) begin
                        count_ff <= count_ff - 1'b1;
                        state_ff <= S_IDLE;
                     end else begin
                        id_ff[ix]    <= id_ff[ixp1];
                        score_ff[ix] <= score_ff[ixp1];
                        idx_ff       <= idx_ff + 1'b1;
                     end
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end
endmodule

// ===== design/sorted_score_table_top.sv =====
// Top level of the sorted score table: request queue front end and table
// back end. Uses sst_pkg, sst_front and sst_back.
//
//   channel  handshake         payload
//   req      req_push/full     req_mode, req_player_id, req_score
//   rsp      rsp_pop/empty     rsp_status, rsp_out_id, rsp_out_score, rsp_last
//
// One word at a time in the back end: from idle it walks the entries (scan,
// shift or report), and a behind query scans to the id and then reports back.
// Reset is synchronous and empties the table and both queues.
// A full result queue stalls the back end; the request queue holds two words.
module sorted_score_table_top import sst_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [2:0]           req_mode,
   input  logic [IdBits-1:0]    req_player_id,
   input  logic [ScoreBits-1:0] req_score,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [2:0]           rsp_status,
   output logic [IdBits-1:0]    rsp_out_id,
   output logic [ScoreBits-1:0] rsp_out_score,
   output logic                 rsp_last
);
   logic    cmd_valid, cmd_take;
   cmd_type cmd;

   sst_front u_front (
      .clock, .reset, .req_push, .req_full, .req_mode, .req_player_id, .req_score,
      .cmd_valid, .cmd, .cmd_take
   );

   sst_back u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_take, .rsp_empty, .rsp_pop,
      .rsp_status, .rsp_out_id, .rsp_out_score, .rsp_last
   );
endmodule

// ===== design/sst_checker.sv =====
// Port checker for the sorted score table, bound to the top level.
// Uses sst_pkg.
module sst_checker import sst_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_full,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input logic [2:0]           rsp_status,
   input logic [IdBits-1:0]    rsp_out_id,
   input logic                 rsp_last
);
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_status <= ST_NOMATCH) else $error("bad status");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_id))
      else $error("result dropped");
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status != ST_ENTRY |-> rsp_last) else $error("last missing");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty && !req_full) else $error("reset state");
endmodule

bind sorted_score_table_top sst_checker u_chk (
   .clock, .reset, .req_full, .rsp_empty, .rsp_pop, .rsp_status,
   .rsp_out_id, .rsp_last
);
